// File: rtl/lsg_pkg.sv
// Shared types and constants of the LED strip effect generator.
package lsg_pkg;

    // Field widths of the channels and registers
    localparam int MODE_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int TICKS_W    = 24;
    localparam int LEVEL_W    = 8;
    localparam int COLOUR_W   = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Front queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_LED_COUNT       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BREATHING_TICKS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STEADY_TICKS    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FLASHING_TICKS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TEST_TICKS      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_HIGH      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LEVEL_LOW       = 3'd6;

    // Register reset values
    localparam logic [COUNT_W-1:0] RST_LED_COUNT       = 9'd60;
    localparam logic [TICKS_W-1:0] RST_BREATHING_TICKS = 24'd10000;
    localparam logic [TICKS_W-1:0] RST_STEADY_TICKS    = 24'd100000;
    localparam logic [TICKS_W-1:0] RST_FLASHING_TICKS  = 24'd500000;
    localparam logic [TICKS_W-1:0] RST_TEST_TICKS      = 24'd100000;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_HIGH      = 8'd255;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_LOW       = 8'd0;

    // Effect codes
    localparam logic [MODE_W-1:0] MODE_BREATHE_WHITE = 4'd0;
    localparam logic [MODE_W-1:0] MODE_BREATHE_GREEN = 4'd1;
    localparam logic [MODE_W-1:0] MODE_BREATHE_BLUE  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_STEADY_BLUE   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_STEADY_GREEN  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_STEADY_RED    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_STEADY_BLACK  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FLASH_RED     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_TEST          = 4'd8;

    // Effect phases
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // LED words: brightness, blue, green, red from the top byte down
    localparam logic [COLOUR_W-1:0] COL_BLACK    = 32'hE000_0000;
    localparam logic [COLOUR_W-1:0] COL_TEST_LIT = 32'hEB00_00FF;
    localparam logic [COLOUR_W-1:0] COL_RED      = 32'hFF00_00FF;
    localparam logic [COLOUR_W-1:0] COL_GREEN    = 32'hFF00_FF00;
    localparam logic [COLOUR_W-1:0] COL_BLUE     = 32'hFFFF_0000;

    localparam logic [7:0] BYTE_START = 8'h00;
    localparam logic [7:0] BYTE_END   = 8'hFF;
    localparam logic [7:0] BRIGHT_MAX = 8'hFF;

    // Live configuration handed to the engine
    typedef struct packed {
        logic [COUNT_W-1:0] led_count;
        logic [TICKS_W-1:0] breathing_ticks;
        logic [TICKS_W-1:0] steady_ticks;
        logic [TICKS_W-1:0] flashing_ticks;
        logic [TICKS_W-1:0] test_ticks;
        logic [LEVEL_W-1:0] level_high;
        logic [LEVEL_W-1:0] level_low;
    } cfg_t;

    // One classified tick waiting in the queue
    typedef struct packed {
        logic              change_req;
        logic [MODE_W-1:0] mode;
    } item_t;

endpackage

// File: rtl/led_strip_effect_generator.sv
// Top level of the LED strip effect generator: registers, tick queue and effect engine.
//
//  channel   dir   handshake                    payload
//  s_        in    s_tvalid / s_tready          s_tdata: effect_write, mode
//  m_        out   m_tvalid / m_tready          m_tdata: frame_byte, m_tuser, m_tlast
//  apb       in    psel / penable / pready      paddr, pwdata, prdata
//
//  One tick per clock cycle while s_tready is high; the engine retires one queued tick a cycle unless m_ stalls.
//  A frame byte reaches m_ through the tick queue and then the output register.
//  Reset is synchronous on aresetn low; no clearing pass follows it.
//  With m_tready low the output register holds and the two-entry queue fills,
//  after which s_tready drops until the result is taken.
module led_strip_effect_generator #(
    parameter int MAX_LEDS   = 256,
    parameter int DELAY_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lsg_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] effect_write, [4:1] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsg_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] frame_byte
    output logic                            m_tlast,   // frame_last
    output logic                            m_tuser,   // [0] frame_first
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lsg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lsg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import lsg_pkg::*;

    cfg_t  cfg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    lsg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lsg_back #(
        .MAX_LEDS   (MAX_LEDS),
        .DELAY_BITS (DELAY_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/lsg_regs.sv
// APB configuration register file of the LED strip effect generator.
module lsg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lsg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lsg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output lsg_pkg::cfg_t                   cfg
);
    import lsg_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_LED_COUNT:       cfg_next.led_count       = pwdata[COUNT_W-1:0];
                REG_BREATHING_TICKS: cfg_next.breathing_ticks = pwdata[TICKS_W-1:0];
                REG_STEADY_TICKS:    cfg_next.steady_ticks    = pwdata[TICKS_W-1:0];
                REG_FLASHING_TICKS:  cfg_next.flashing_ticks  = pwdata[TICKS_W-1:0];
                REG_TEST_TICKS:      cfg_next.test_ticks      = pwdata[TICKS_W-1:0];
                REG_LEVEL_HIGH:      cfg_next.level_high      = pwdata[LEVEL_W-1:0];
                REG_LEVEL_LOW:       cfg_next.level_low       = pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.led_count       <= RST_LED_COUNT;
            cfg_reg.breathing_ticks <= RST_BREATHING_TICKS;
            cfg_reg.steady_ticks    <= RST_STEADY_TICKS;
            cfg_reg.flashing_ticks  <= RST_FLASHING_TICKS;
            cfg_reg.test_ticks      <= RST_TEST_TICKS;
            cfg_reg.level_high      <= RST_LEVEL_HIGH;
            cfg_reg.level_low       <= RST_LEVEL_LOW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_LED_COUNT:       prdata = APB_DATA_W'(cfg_reg.led_count);
            REG_BREATHING_TICKS: prdata = APB_DATA_W'(cfg_reg.breathing_ticks);
            REG_STEADY_TICKS:    prdata = APB_DATA_W'(cfg_reg.steady_ticks);
            REG_FLASHING_TICKS:  prdata = APB_DATA_W'(cfg_reg.flashing_ticks);
            REG_TEST_TICKS:      prdata = APB_DATA_W'(cfg_reg.test_ticks);
            REG_LEVEL_HIGH:      prdata = APB_DATA_W'(cfg_reg.level_high);
            REG_LEVEL_LOW:       prdata = APB_DATA_W'(cfg_reg.level_low);
            default:             prdata = '0;
        endcase
    end

endmodule

// File: rtl/lsg_front.sv
// Input side: accepts ticks, classifies effect requests and queues them.
module lsg_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lsg_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] effect_write, [4:1] mode
    output logic                           q_valid,
    output lsg_pkg::item_t                 q_item,
    input  logic                           q_pop
);
    import lsg_pkg::*;

    item_t             q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    item_t             cls_item;

    // Classify: only an in-range mode with the write flag asks for a change
    always_comb begin
        cls_item.mode       = s_tdata[MODE_W:1];
        cls_item.change_req = s_tdata[0] &&
                              (cls_item.mode inside {[MODE_BREATHE_WHITE:MODE_TEST]});
    end

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // Queue pointers
    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

// File: rtl/lsg_back.sv
// Effect engine: runs one tick per cycle while the output is not stalled, and registers the frame byte.
module lsg_back #(
    parameter int MAX_LEDS   = 256,
    parameter int DELAY_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lsg_pkg::cfg_t                  cfg,
    input  logic                           q_valid,
    input  lsg_pkg::item_t                 q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lsg_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] frame_byte
    output logic                           m_tlast,   // frame_last
    output logic                           m_tuser    // frame_first
);
    import lsg_pkg::*;

    localparam int N_BITS   = $clog2(MAX_LEDS + 1);
    localparam int IDX_BITS = N_BITS + 3;
    localparam int LED_BITS = IDX_BITS - 2;
    localparam int CNT_W    = (N_BITS > COUNT_W) ? N_BITS : COUNT_W;
    localparam int SAT_W    = (DELAY_BITS > TICKS_W) ? DELAY_BITS : TICKS_W;
    localparam logic [CNT_W-1:0] MAX_N     = CNT_W'(MAX_LEDS);
    localparam logic [SAT_W-1:0] DELAY_MAX = SAT_W'((64'd1 << DELAY_BITS) - 64'd1);

    function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [TICKS_W-1:0] t);
        logic [SAT_W-1:0] te;
        te = SAT_W'(t);
        if (te > DELAY_MAX) te = DELAY_MAX;
        return DELAY_BITS'(te);
    endfunction

    // Effect state
    logic [MODE_W-1:0]     cur_reg,     cur_next;
    logic [1:0]            phase_reg,   phase_next;
    logic [LEVEL_W-1:0]    ramp_reg,    ramp_next;
    logic [N_BITS-1:0]     lit_reg,     lit_next;
    logic [COLOUR_W-1:0]   colour_reg,  colour_next;
    logic [N_BITS-1:0]     flit_reg,    flit_next;
    logic [IDX_BITS-1:0]   idx_reg,     idx_next;
    logic [DELAY_BITS-1:0] wait_reg,    wait_next;
    logic                  sending_reg, sending_next;

    // Output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]     byte_reg,     byte_next;
    logic                  first_reg,    first_next;
    logic                  last_reg,     last_next;

    // Working values
    logic [CNT_W-1:0]      n_wide;
    logic [N_BITS-1:0]     n;
    logic [IDX_BITS-1:0]   total;
    logic [MODE_W-1:0]     cur_w;
    logic [1:0]            phase_w;
    logic [LEVEL_W-1:0]    ramp_w;
    logic [N_BITS-1:0]     lit_w;
    logic                  sf_ok;
    logic [MODE_W-1:0]     sf_cur;
    logic [1:0]            sf_phase;
    logic [LEVEL_W-1:0]    sf_ramp;
    logic [N_BITS-1:0]     sf_lit;
    logic [COLOUR_W-1:0]   sf_colour;
    logic [N_BITS-1:0]     sf_flit;
    logic [DELAY_BITS-1:0] sf_wait;
    logic [LEVEL_W-1:0]    lv;
    logic [LED_BITS-1:0]   led;
    logic [COLOUR_W-1:0]   col;
    logic [BYTE_W-1:0]     tx_byte;
    logic                  tx_last;

    // Strip length from the live register
    always_comb begin
        n_wide = CNT_W'(cfg.led_count);
        if (n_wide == '0) begin
            n_wide = CNT_W'(1);
        end else if (n_wide > MAX_N) begin
            n_wide = MAX_N;
        end
        n     = N_BITS'(n_wide);
        total = (IDX_BITS'(n) << 2) + IDX_BITS'(8);
    end

    // Effect write takes hold first, unless the test sweep runs or the mode is unchanged
    always_comb begin
        cur_w   = cur_reg;
        phase_w = phase_reg;
        ramp_w  = ramp_reg;
        lit_w   = lit_reg;
        if (q_item.change_req && (cur_reg != MODE_TEST) && (q_item.mode != cur_reg)) begin
            cur_w   = q_item.mode;
            phase_w = PH_FIRST;
            ramp_w  = cfg.level_high;
            lit_w   = N_BITS'(1);
        end
    end

    // Next-frame decision
    always_comb begin
        sf_ok     = 1'b1;
        sf_cur    = cur_w;
        sf_phase  = phase_w;
        sf_ramp   = ramp_w;
        sf_lit    = lit_w;
        sf_colour = COL_BLACK;
        sf_flit   = n;
        sf_wait   = sat_delay(cfg.steady_ticks);
        lv        = ramp_w;
        case (cur_w)
            MODE_BREATHE_WHITE, MODE_BREATHE_GREEN, MODE_BREATHE_BLUE: begin
                if (cfg.level_high < cfg.level_low) begin
                    // empty ramp: no frame
                    sf_ok    = 1'b0;
                    sf_phase = PH_FIRST;
                    sf_ramp  = cfg.level_high;
                end else begin
                    lv = ramp_w;
                    if (lv > cfg.level_high) lv = cfg.level_high;
                    if (lv < cfg.level_low)  lv = cfg.level_low;
                    if (cur_w == MODE_BREATHE_WHITE) begin
                        sf_colour = {BRIGHT_MAX, lv, lv, lv};
                    end else if (cur_w == MODE_BREATHE_GREEN) begin
                        sf_colour = {BRIGHT_MAX, 8'h00, lv, 8'h00};
                    end else begin
                        sf_colour = {BRIGHT_MAX, lv, 8'h00, 8'h00};
                    end
                    sf_ramp = lv;
                    if (phase_w == PH_SECOND) begin
                        if (lv < cfg.level_high) begin
                            sf_ramp = lv + 1'b1;
                        end else begin
                            sf_phase = PH_FIRST;
                            sf_ramp  = cfg.level_high;
                        end
                    end else begin
                        if (lv > cfg.level_low) begin
                            sf_ramp = lv - 1'b1;
                        end else begin
                            sf_phase = PH_SECOND;
                            sf_ramp  = cfg.level_low;
                        end
                    end
                    sf_wait = sat_delay(cfg.breathing_ticks);
                end
            end
            MODE_STEADY_BLUE:  sf_colour = COL_BLUE;
            MODE_STEADY_GREEN: sf_colour = COL_GREEN;
            MODE_STEADY_RED:   sf_colour = COL_RED;
            MODE_STEADY_BLACK: sf_colour = COL_BLACK;
            MODE_FLASH_RED: begin
                if (phase_w == PH_SECOND) begin
                    sf_colour = COL_RED;
                    sf_phase  = PH_FIRST;
                end else begin
                    sf_colour = COL_BLACK;
                    sf_phase  = PH_SECOND;
                end
                sf_wait = sat_delay(cfg.flashing_ticks);
            end
            MODE_TEST: begin
                if (phase_w[1]) begin
                    // sweep over: fall back to steady black
                    sf_cur    = MODE_STEADY_BLACK;
                    sf_phase  = PH_FIRST;
                    sf_colour = COL_BLACK;
                end else begin
                    if (sf_lit == '0) sf_lit = N_BITS'(1);
                    if ((sf_phase == PH_FIRST) && (sf_lit >= n)) begin
                        sf_phase = PH_SECOND;
                        sf_lit   = n;
                    end
                    if ((sf_phase == PH_SECOND) && (sf_lit > n)) sf_lit = n;
                    sf_colour = COL_TEST_LIT;
                    sf_flit   = sf_lit;
                    if (sf_phase == PH_FIRST) begin
                        sf_lit = sf_lit + 1'b1;
                    end else if (sf_lit > N_BITS'(1)) begin
                        sf_lit = sf_lit - 1'b1;
                    end else begin
                        sf_phase = PH_DONE;
                    end
                    sf_wait = sat_delay(cfg.test_ticks);
                end
            end
            default: sf_ok = 1'b0;
        endcase
    end

    // Byte of the running frame
    always_comb begin
        led     = LED_BITS'(idx_reg >> 2) - 1'b1;
        col     = (led < LED_BITS'(flit_reg)) ? colour_reg : COL_BLACK;
        tx_last = (idx_reg + 1'b1) >= total;
        if (idx_reg < IDX_BITS'(4)) begin
            tx_byte = BYTE_START;
        end else if ((idx_reg + IDX_BITS'(4)) >= total) begin
            tx_byte = BYTE_END;
        end else begin
            case (idx_reg[1:0])
                2'd0:    tx_byte = col[31:24];
                2'd1:    tx_byte = col[23:16];
                2'd2:    tx_byte = col[15:8];
                default: tx_byte = col[7:0];
            endcase
        end
    end

    // Tick execution
    always_comb begin
        q_pop         = q_valid && (!m_tvalid_reg || m_tready);
        cur_next      = cur_reg;
        phase_next    = phase_reg;
        ramp_next     = ramp_reg;
        lit_next      = lit_reg;
        colour_next   = colour_reg;
        flit_next     = flit_reg;
        idx_next      = idx_reg;
        wait_next     = wait_reg;
        sending_next  = sending_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        byte_next     = byte_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        if (q_pop) begin
            cur_next   = cur_w;
            phase_next = phase_w;
            ramp_next  = ramp_w;
            lit_next   = lit_w;
            if (!sending_reg) begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else begin
                    cur_next   = sf_cur;
                    phase_next = sf_phase;
                    ramp_next  = sf_ramp;
                    lit_next   = sf_lit;
                    if (sf_ok) begin
                        // first byte of a new frame is always a start byte
                        colour_next   = sf_colour;
                        flit_next     = sf_flit;
                        wait_next     = sf_wait;
                        sending_next  = 1'b1;
                        idx_next      = IDX_BITS'(1);
                        m_tvalid_next = 1'b1;
                        byte_next     = BYTE_START;
                        first_next    = 1'b1;
                        last_next     = 1'b0;
                    end
                end
            end else begin
                m_tvalid_next = 1'b1;
                byte_next     = tx_byte;
                first_next    = (idx_reg == '0);
                last_next     = tx_last;
                if (tx_last) begin
                    sending_next = 1'b0;
                    idx_next     = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg      <= MODE_BREATHE_WHITE;
            phase_reg    <= PH_FIRST;
            ramp_reg     <= 8'd255;
            lit_reg      <= N_BITS'(1);
            colour_reg   <= '0;
            flit_reg     <= '0;
            idx_reg      <= '0;
            wait_reg     <= '0;
            sending_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cur_reg      <= cur_next;
            phase_reg    <= phase_next;
            ramp_reg     <= ramp_next;
            lit_reg      <= lit_next;
            colour_reg   <= colour_next;
            flit_reg     <= flit_next;
            idx_reg      <= idx_next;
            wait_reg     <= wait_next;
            sending_reg  <= sending_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        first_reg <= first_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = first_reg;
    assign m_tlast  = last_reg;

    a_first_is_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == BYTE_START && !m_tlast))
        else $error("frame start item not a zero byte");

    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata == BYTE_END))
        else $error("frame end item not an end byte");

endmodule
